// ----- rtl/core/btrl_pkg.sv -----
// Package for the binary trie route lookup: sizes, node type, codes and states.
`default_nettype none
package btrl_pkg;

  localparam int unsigned NODE_COUNT = 65536;
  localparam int unsigned PORT_BITS  = 16;
  localparam int unsigned IDX_W      = $clog2(NODE_COUNT);
  localparam int unsigned FREE_W     = IDX_W + 1;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PLEN_W     = 6;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned LEVEL_W    = 6;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(ADDR_W);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_STEP  = 2'd1,
    S_CLEAR = 2'd2
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0]     child1;
    logic [IDX_W-1:0]     child0;
    logic                 valid;
    logic [PORT_BITS-1:0] port;
  } node_t;

endpackage
`default_nettype wire

// ----- rtl/core/btrl_if.sv -----
// Request and response channel interfaces of the binary trie route lookup.
`default_nettype none
interface btrl_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [btrl_pkg::ADDR_W-1:0]   address;
  logic [btrl_pkg::PLEN_W-1:0]   prefix_len;
  logic [btrl_pkg::PORT_W-1:0]   route_port;

  modport source (output valid, op, address, prefix_len, route_port, input ready);
  modport sink   (input valid, op, address, prefix_len, route_port, output ready);
endinterface

interface btrl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [btrl_pkg::STATUS_W-1:0] status;
  logic [btrl_pkg::PORT_W-1:0]   match_port;

  modport source (output valid, status, match_port, input ready);
  modport sink   (input valid, status, match_port, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/binary_trie_route_lookup.sv -----
// Binary trie longest-prefix match for IPv4 routes, with its node store.
// Usage: each request transaction on req_i is an insert (op 0: address,
// prefix_len, route_port) or a lookup (op 1: address). Each request gives
// exactly one response transaction on rsp_o with status and match_port.
// Requests are taken one at a time; req_i.ready is high while the walker is idle.
// The walker descends one trie level per cycle, bound by the registered read
// of the node memory; an insert also spends a clear step on every node it
// allocates.
// The response sits in an output register, so a new request is accepted while
// the previous response waits; a walk that finishes while that register is
// still full holds in place until rsp_o.ready frees it.
// Reset empties the trie: the root turns invalid with no children and the
// free pointer returns to the first node. Node memory contents need no
// clearing, since a node is written with zeros when it is allocated.
`default_nettype none
module binary_trie_route_lookup (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  btrl_req_if.sink    req_i,
  btrl_rsp_if.source  rsp_o
);

  btrl_pkg::node_t                   mem_q [btrl_pkg::NODE_COUNT];
  btrl_pkg::node_t                   rd_data_q;

  btrl_pkg::state_e                  state_q, state_d;
  btrl_pkg::node_t                   root_q, root_d;
  btrl_pkg::node_t                   cur_node_q, cur_node_d;
  logic [btrl_pkg::IDX_W-1:0]        cur_idx_q, cur_idx_d;
  logic                              use_rd_q, use_rd_d;
  logic [btrl_pkg::FREE_W-1:0]       next_free_q, next_free_d;
  logic [btrl_pkg::LEVEL_W-1:0]      level_q, level_d;
  logic [btrl_pkg::LEVEL_W-1:0]      plen_q, plen_d;
  logic [btrl_pkg::ADDR_W-1:0]       addr_q, addr_d;
  logic                              op_q, op_d;
  logic [btrl_pkg::PORT_BITS-1:0]    rport_q, rport_d;
  logic                              hit_q, hit_d;
  logic [btrl_pkg::PORT_BITS-1:0]    hport_q, hport_d;
  logic                              out_valid_q, out_valid_d;
  logic [btrl_pkg::STATUS_W-1:0]     status_q, status_d;
  logic [btrl_pkg::PORT_W-1:0]       found_q, found_d;

  logic                              mem_we, mem_re;
  logic [btrl_pkg::IDX_W-1:0]        mem_waddr, mem_raddr;
  btrl_pkg::node_t                   mem_wdata;

  btrl_pkg::node_t                   node_c, wr_node_c;
  logic [btrl_pkg::IDX_W-1:0]        child_c;
  logic                              bit_c, out_free_c, wr_c;
  logic                              hit_n;
  logic [btrl_pkg::PORT_BITS-1:0]    hport_n;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btrl_pkg::S_IDLE;
      root_q      <= '0;
      next_free_q <= btrl_pkg::FREE_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      root_q      <= root_d;
      next_free_q <= next_free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_node_q <= cur_node_d;
    cur_idx_q  <= cur_idx_d;
    use_rd_q   <= use_rd_d;
    level_q    <= level_d;
    plen_q     <= plen_d;
    addr_q     <= addr_d;
    op_q       <= op_d;
    rport_q    <= rport_d;
    hit_q      <= hit_d;
    hport_q    <= hport_d;
    status_q   <= status_d;
    found_q    <= found_d;
  end

  assign node_c     = use_rd_q ? rd_data_q : cur_node_q;
  assign bit_c      = addr_q[btrl_pkg::ADDR_W-1];
  assign child_c    = bit_c ? node_c.child1 : node_c.child0;
  assign out_free_c = !out_valid_q || rsp_o.ready;
  assign hit_n      = hit_q || node_c.valid;
  assign hport_n    = node_c.valid ? node_c.port : hport_q;

  always_comb begin
    state_d     = state_q;
    root_d      = root_q;
    cur_node_d  = cur_node_q;
    cur_idx_d   = cur_idx_q;
    use_rd_d    = use_rd_q;
    next_free_d = next_free_q;
    level_d     = level_q;
    plen_d      = plen_q;
    addr_d      = addr_q;
    op_d        = op_q;
    rport_d     = rport_q;
    hit_d       = hit_q;
    hport_d     = hport_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    status_d    = status_q;
    found_d     = found_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_idx_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = child_c;
    wr_c        = 1'b0;
    wr_node_c   = node_c;
    req_i.ready = (state_q == btrl_pkg::S_IDLE);

    case (state_q)
      btrl_pkg::S_IDLE: begin
        if (req_i.valid) begin
          op_d       = req_i.op;
          addr_d     = req_i.address;
          plen_d     = (req_i.prefix_len > btrl_pkg::MAX_LEVEL) ? btrl_pkg::MAX_LEVEL
                                                                : req_i.prefix_len;
          rport_d    = btrl_pkg::PORT_BITS'(req_i.route_port);
          cur_idx_d  = '0;
          cur_node_d = root_q;
          use_rd_d   = 1'b0;
          level_d    = '0;
          hit_d      = 1'b0;
          hport_d    = '0;
          state_d    = btrl_pkg::S_STEP;
        end
      end
      btrl_pkg::S_STEP: begin
        if (op_q == btrl_pkg::OP_LOOKUP) begin
          if (level_q == btrl_pkg::MAX_LEVEL || child_c == '0) begin
            if (out_free_c) begin
              out_valid_d = 1'b1;
              status_d    = hit_n ? btrl_pkg::ST_OK : btrl_pkg::ST_MISS;
              found_d     = hit_n ? btrl_pkg::PORT_W'(hport_n) : '0;
              state_d     = btrl_pkg::S_IDLE;
            end
          end else begin
            hit_d     = hit_n;
            hport_d   = hport_n;
            mem_re    = 1'b1;
            cur_idx_d = child_c;
            use_rd_d  = 1'b1;
            level_d   = level_q + 1'b1;
            addr_d    = addr_q << 1;
          end
        end else begin
          if (level_q == plen_q) begin
            if (out_free_c) begin
              wr_c            = 1'b1;
              wr_node_c.valid = 1'b1;
              wr_node_c.port  = rport_q;
              out_valid_d     = 1'b1;
              status_d        = btrl_pkg::ST_OK;
              found_d         = '0;
              state_d         = btrl_pkg::S_IDLE;
            end
          end else if (child_c != '0) begin
            mem_re    = 1'b1;
            cur_idx_d = child_c;
            use_rd_d  = 1'b1;
            level_d   = level_q + 1'b1;
            addr_d    = addr_q << 1;
          end else if (next_free_q == btrl_pkg::FREE_W'(btrl_pkg::NODE_COUNT)) begin
            if (out_free_c) begin
              out_valid_d = 1'b1;
              status_d    = btrl_pkg::ST_FULL;
              found_d     = '0;
              state_d     = btrl_pkg::S_IDLE;
            end
          end else begin
            wr_c = 1'b1;
            if (bit_c) begin
              wr_node_c.child1 = next_free_q[btrl_pkg::IDX_W-1:0];
            end else begin
              wr_node_c.child0 = next_free_q[btrl_pkg::IDX_W-1:0];
            end
            cur_idx_d   = next_free_q[btrl_pkg::IDX_W-1:0];
            cur_node_d  = '0;
            use_rd_d    = 1'b0;
            next_free_d = next_free_q + 1'b1;
            level_d     = level_q + 1'b1;
            addr_d      = addr_q << 1;
            state_d     = btrl_pkg::S_CLEAR;
          end
        end
      end
      btrl_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_idx_q;
        mem_wdata = '0;
        state_d   = btrl_pkg::S_STEP;
      end
      default: begin
        state_d = btrl_pkg::S_IDLE;
      end
    endcase

    if (wr_c) begin
      if (cur_idx_q == '0) begin
        root_d = wr_node_c;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = cur_idx_q;
        mem_wdata = wr_node_c;
      end
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.match_port = found_q;

endmodule
`default_nettype wire
